>>> rtl/core/wrs_pkg.sv
// wrs_pkg: sizes, codes and shared types of the weighted random select block.
// No dependencies; imported by every module of the block.
package wrs_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int VALUE_W     = 32;
	localparam int WEIGHT_W    = 16;
	localparam int FRAC_W      = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int PREFIX_W    = WEIGHT_W + IDX_W;
	localparam int TARGET_W    = FRAC_W + PREFIX_W;
	localparam int GROUP       = 8;
	localparam int NUM_GROUPS  = (MAX_ENTRIES + GROUP - 1) / GROUP;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_ZERO_W = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                wr_en;
		logic [CNT_W-1:0]    count;
		logic [VALUE_W-1:0]  wr_value;
		logic [PREFIX_W-1:0] wr_prefix;
		logic [TARGET_W-1:0] target;
	} cell_ctrl_t;

	// per-cell pick, zero unless the cell is the chosen entry
	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] value;
	} pick_t;

endpackage

>>> rtl/core/weighted_random_select_top.sv
// weighted_random_select_top: controller, row of entry cells and pick tree.
// Depends on wrs_pkg, wrs_cell, wrs_reduce.
//
// Usage: an item is taken when start is high and busy is low. operation picks
// clear, load or select; entry_value/entry_weight go with a load and
// random_fraction with a select. Every item gives one result: done is high
// for one cycle with selected_index, selected_value and status.
// Clear, load, any unused operation and a select that cannot search (empty
// table or a zero weight loaded) answer in the cycle after the item, and busy
// stays low, so such items can be issued every cycle.
// A searching select passes through the product r*total, the parallel compare
// in every cell, the first-hit pick against the neighbor flag, and two levels
// of the OR tree. busy is high from S_CMP through S_OUT, so no new item is
// taken while a select is searching.
// Reset clears the entry count, the zero-weight mark, the running total and
// the sequencer; the table contents need no reset since only loaded entries
// are searched. The receiver cannot stall: results are not held.
module weighted_random_select_top
	import wrs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  entry_value,
	input  logic [15:0]         entry_weight,
	input  logic [15:0]         random_fraction,
	output logic                done,
	output logic [5:0]          selected_index,
	output logic signed [31:0]  selected_value,
	output logic [1:0]          status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_PICK = 3'd2;
	localparam logic [2:0] S_TREE = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic                zero_seen_q;
	logic [PREFIX_W-1:0] total_q;
	logic [TARGET_W-1:0] target_s1;
	logic                accept;
	logic                load_ok;
	cell_ctrl_t          ctrl;
	logic                flags [MAX_ENTRIES+1];
	pick_t               picks [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hit_vec;
	pick_t               merged;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign load_ok = accept && (operation == OP_LOAD) && (count_q < CNT_W'(MAX_ENTRIES));

	assign ctrl.wr_en     = load_ok;
	assign ctrl.count     = count_q;
	assign ctrl.wr_value  = VALUE_W'(entry_value);
	assign ctrl.wr_prefix = total_q + PREFIX_W'(entry_weight);
	assign ctrl.target    = target_s1;

	assign flags[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		wrs_cell u_cell (
			.clk      (clk),
			.cell_idx (IDX_W'(i)),
			.ctrl     (ctrl),
			.flag_in  (flags[i]),
			.flag_out (flags[i+1]),
			.pick     (picks[i])
		);
		assign hit_vec[i] = picks[i].hit;
	end

	wrs_reduce u_reduce (
		.clk    (clk),
		.picks  (picks),
		.merged (merged)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			target_s1 <= TARGET_W'(random_fraction) * TARGET_W'(total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			zero_seen_q <= 1'b0;
			total_q     <= '0;
			done        <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_CLEAR: begin
								count_q     <= '0;
								zero_seen_q <= 1'b0;
								total_q     <= '0;
								done        <= 1'b1;
							end
							OP_LOAD: begin
								if (load_ok) begin
									count_q <= count_q + 1'b1;
									total_q <= ctrl.wr_prefix;
									if (entry_weight == '0) begin
										zero_seen_q <= 1'b1;
									end
								end
								done <= 1'b1;
							end
							OP_SELECT: begin
								if (count_q == '0 || zero_seen_q) begin
									done <= 1'b1;
								end else begin
									state_q <= S_CMP;
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_CMP:  state_q <= S_PICK;
				S_PICK: state_q <= S_TREE;
				S_TREE: state_q <= S_OUT;
				S_OUT: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			selected_index <= 6'(merged.idx);
			selected_value <= 32'(signed'(merged.value));
			status         <= ST_OK;
		end else if (accept) begin
			selected_index <= '0;
			selected_value <= '0;
			status         <= ST_OK;
			case (operation)
				OP_LOAD: begin
					if (!load_ok) begin
						status <= ST_FULL;
					end else if (entry_weight == '0) begin
						status <= ST_ZERO_W;
					end
				end
				OP_SELECT: begin
					if (count_q == '0) begin
						status <= ST_EMPTY;
					end else if (zero_seen_q) begin
						status <= ST_ZERO_W;
					end
				end
				default: status <= ST_OK;
			endcase
		end
	end

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TREE |-> $onehot(hit_vec))
		else $error("search did not find exactly one entry");

	a_tree_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> merged.hit)
		else $error("pick tree lost the chosen entry");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> count_q == $past(count_q))
		else $error("table changed during a select");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept) || $past(state_q == S_OUT))
		else $error("result without an item");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count past table size");

endmodule

>>> rtl/core/wrs_cell.sv
// wrs_cell: one table entry (value, prefix sum) with its compare and pick stages.
// Depends on wrs_pkg. Takes the compare flag of its left neighbor.
module wrs_cell
	import wrs_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] cell_idx,
	input  cell_ctrl_t       ctrl,
	input  logic             flag_in,
	output logic             flag_out,
	output pick_t            pick
);

	logic [VALUE_W-1:0]  value_q;
	logic [PREFIX_W-1:0] prefix_q;
	logic                flag_s2;
	logic                in_use;
	logic                wr_here;

	assign in_use  = {1'b0, cell_idx} < ctrl.count;
	assign wr_here = ctrl.wr_en && (ctrl.count[IDX_W-1:0] == cell_idx);

	always_ff @(posedge clk) begin
		if (wr_here) begin
			value_q  <= ctrl.wr_value;
			prefix_q <= ctrl.wr_prefix;
		end
	end

	// prefix sums rise along the row, so the flags form a thermometer;
	// the first set flag is where the left neighbor's flag is clear
	always_ff @(posedge clk) begin
		flag_s2    <= in_use && ({prefix_q, FRAC_W'(0)} > ctrl.target);
		pick.hit   <= flag_s2 && !flag_in;
		pick.idx   <= (flag_s2 && !flag_in) ? cell_idx : '0;
		pick.value <= (flag_s2 && !flag_in) ? value_q : '0;
	end

	assign flag_out = flag_s2;

endmodule

>>> rtl/core/wrs_reduce.sv
// wrs_reduce: OR tree over the cell picks, one register level in groups of eight.
// Depends on wrs_pkg.
module wrs_reduce
	import wrs_pkg::*;
(
	input  logic  clk,
	input  pick_t picks [MAX_ENTRIES],
	output pick_t merged
);

	pick_t grp_s4 [NUM_GROUPS];

	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			pick_t acc;
			acc = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < MAX_ENTRIES) begin
					acc = acc | picks[g * GROUP + j];
				end
			end
			grp_s4[g] <= acc;
		end
	end

	always_comb begin
		merged = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			merged = merged | grp_s4[g];
		end
	end

endmodule
